FILE: rtl/kvz_pkg.sv
// kvz_pkg: shared types, codes and defaults of the key and velocity zone lookup
// used by kvz_zone_cmp, the core and the bench; depends on nothing

package kvz_pkg;

    localparam int DEF_ZONES   = 1024;
    localparam int DEF_PRESETS = 128;

    // field widths fixed by the item format
    localparam int NOTE_W   = 7;
    localparam int PIDX_W   = 8;
    localparam int ZIDX_W   = 10;
    localparam int COUNT_W  = 11;
    localparam int WALK_W   = 12;   // first_zone + zone_count fits here
    localparam int ACT_W    = 2;
    localparam int CFG_AW   = 2;
    localparam int CFG_DW   = 11;
    localparam int S_DATA_W = 88;
    localparam int M_DATA_W = 16;

    localparam logic [ACT_W-1:0] ACT_WR_PRESET = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WR_ZONE   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_LOOKUP    = 2'd2;

    localparam logic [CFG_AW-1:0] CFG_TABLE_LOADED   = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_PRESETS_IN_USE = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_ZONES_IN_USE   = 2'd2;

    typedef struct packed {
        logic [COUNT_W-1:0] zone_count;
        logic [ZIDX_W-1:0]  first_zone;
    } preset_entry_t;

    typedef struct packed {
        logic [NOTE_W-1:0] vel_high;
        logic [NOTE_W-1:0] vel_low;
        logic [NOTE_W-1:0] key_high;
        logic [NOTE_W-1:0] key_low;
    } zone_entry_t;

endpackage

FILE: rtl/kvz_ram.sv
// kvz_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module kvz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/kvz_zone_cmp.sv
// kvz_zone_cmp: range compare unit shared by every step of the zone walk
// depends on kvz_pkg

module kvz_zone_cmp
    import kvz_pkg::*;
(
    input  zone_entry_t       zone,
    input  logic [NOTE_W-1:0] note,
    input  logic [NOTE_W-1:0] vel,
    output logic              hit
);

    logic key_ok;
    logic vel_ok;

    // inverted ranges fail on their own
    assign key_ok = (note >= zone.key_low) && (note <= zone.key_high);
    assign vel_ok = (vel >= zone.vel_low) && (vel <= zone.vel_high);
    assign hit    = key_ok && vel_ok;

endmodule

FILE: rtl/key_velocity_zone_lookup_core.sv
// key_velocity_zone_lookup_core: preset and zone tables with a walk sequencer
// depends on kvz_pkg, kvz_ram and kvz_zone_cmp
//
// Usage:
//   s_* channel takes items; s_tuser holds the action (write preset, write zone,
//   lookup). Writes store one table entry at the accept edge and give no result.
//   A lookup gives one result item on m_*: m_tuser is found, m_tdata the zone.
//   cfg_we/cfg_addr/cfg_wdata set table_loaded, presets_in_use, zones_in_use;
//   write them only while no item is in flight.
// Timing:
//   s_tready is high only while the sequencer is idle; a write leaves it idle.
//   A lookup reads the preset entry, then checks one zone per cycle through
//   the registered read port of the zone ram and the single compare unit:
//   the result is loaded into the output register once the walk ends, after
//   at most 1024 zones; an early not found skips the preset read and walk.
//   The next item is taken right after that, even while the result still
//   waits in the output register.
// Reset: registers clear, no result pending; table contents are undefined
//   until written. A stalled receiver holds the result; a lookup finishing
//   meanwhile waits for the output register to free up.

module key_velocity_zone_lookup_core
    import kvz_pkg::*;
#(
    parameter int ZONES   = DEF_ZONES,
    parameter int PRESETS = DEF_PRESETS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // preset_index, zone_index, first_zone, zone_count, key_low, key_high,
    // vel_low, vel_high, midi_note, note_velocity, zero fill
    input  logic [S_DATA_W-1:0] s_tdata,
    // action
    input  logic [ACT_W-1:0]    s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // zone_result, zero fill
    output logic [M_DATA_W-1:0] m_tdata,
    // found
    output logic                m_tuser,
    input  logic                cfg_we,
    input  logic [CFG_AW-1:0]   cfg_addr,
    input  logic [CFG_DW-1:0]   cfg_wdata
);

    localparam int PAW = (PRESETS > 1) ? $clog2(PRESETS) : 1;
    localparam int ZAW = (ZONES > 1) ? $clog2(ZONES) : 1;

    typedef enum logic [1:0] {ST_IDLE, ST_PRESET, ST_WALK, ST_DONE} state_t;

    // input fields
    logic [PIDX_W-1:0]  preset_index;
    logic [ZIDX_W-1:0]  zone_index;
    logic [ZIDX_W-1:0]  first_zone;
    logic [COUNT_W-1:0] zone_count;
    logic [NOTE_W-1:0]  key_low;
    logic [NOTE_W-1:0]  key_high;
    logic [NOTE_W-1:0]  vel_low;
    logic [NOTE_W-1:0]  vel_high;
    logic [NOTE_W-1:0]  midi_note;
    logic [NOTE_W-1:0]  note_velocity;

    assign preset_index  = s_tdata[7:0];
    assign zone_index    = s_tdata[17:8];
    assign first_zone    = s_tdata[27:18];
    assign zone_count    = s_tdata[38:28];
    assign key_low       = s_tdata[45:39];
    assign key_high      = s_tdata[52:46];
    assign vel_low       = s_tdata[59:53];
    assign vel_high      = s_tdata[66:60];
    assign midi_note     = s_tdata[73:67];
    assign note_velocity = s_tdata[80:74];

    // configuration registers
    logic               loaded_reg;
    logic [PIDX_W-1:0]  npres_reg;
    logic [COUNT_W-1:0] nzone_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg <= 1'b0;
            npres_reg  <= '0;
            nzone_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_TABLE_LOADED:   loaded_reg <= cfg_wdata[0];
                CFG_PRESETS_IN_USE: npres_reg  <= cfg_wdata[PIDX_W-1:0];
                CFG_ZONES_IN_USE:   nzone_reg  <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    // sequencer registers
    state_t             state_reg,     state_next;
    logic [NOTE_W-1:0]  note_reg,      note_next;
    logic [NOTE_W-1:0]  vel_reg,       vel_next;
    logic [WALK_W-1:0]  idx_reg,       idx_next;
    logic [WALK_W-1:0]  nxt_reg,       nxt_next;
    logic [WALK_W-1:0]  lim_reg,       lim_next;
    logic               res_found_reg, res_found_next;
    logic [ZIDX_W-1:0]  res_zone_reg,  res_zone_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_found_reg, out_found_next;
    logic [ZIDX_W-1:0]  out_zone_reg,  out_zone_next;

    logic               accept;
    logic               lk_ok;
    logic               p_we;
    logic               p_re;
    logic [PAW-1:0]     p_addr;
    preset_entry_t      p_wdata;
    preset_entry_t      p_rdata;
    logic               z_we;
    logic               z_re;
    logic [ZAW-1:0]     z_waddr;
    logic [WALK_W-1:0]  z_addr;
    zone_entry_t        z_wdata;
    zone_entry_t        z_rdata;
    logic               hit;
    logic [WALK_W-1:0]  nz_lim;
    logic [WALK_W-1:0]  walk_first;
    logic [WALK_W-1:0]  walk_end;
    logic [WALK_W-1:0]  walk_lim;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign p_addr  = PAW'(preset_index);
    assign p_wdata = '{zone_count: zone_count, first_zone: first_zone};
    assign p_we    = accept && (s_tuser == ACT_WR_PRESET) && (32'(preset_index) < PRESETS);
    assign lk_ok   = loaded_reg && (preset_index < npres_reg)
                     && (32'(preset_index) < PRESETS);
    assign p_re    = accept && (s_tuser == ACT_LOOKUP) && lk_ok;

    assign z_waddr = ZAW'(zone_index);
    assign z_wdata = '{vel_high: vel_high, vel_low: vel_low,
                       key_high: key_high, key_low: key_low};
    assign z_we    = accept && (s_tuser == ACT_WR_ZONE) && (32'(zone_index) < ZONES);

    // zones_in_use clamped to the table size
    assign nz_lim = (32'(nzone_reg) > ZONES) ? WALK_W'(ZONES) : WALK_W'(nzone_reg);

    assign walk_first = WALK_W'(p_rdata.first_zone);
    assign walk_end   = walk_first + WALK_W'(p_rdata.zone_count);
    assign walk_lim   = (walk_end < nz_lim) ? walk_end : nz_lim;

    kvz_ram #(
        .WIDTH ($bits(preset_entry_t)),
        .DEPTH (PRESETS)
    ) u_preset_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_addr),
        .wdata (p_wdata),
        .re    (p_re),
        .raddr (p_addr),
        .rdata (p_rdata)
    );

    kvz_ram #(
        .WIDTH ($bits(zone_entry_t)),
        .DEPTH (ZONES)
    ) u_zone_ram (
        .clk   (clk),
        .we    (z_we),
        .waddr (z_waddr),
        .wdata (z_wdata),
        .re    (z_re),
        .raddr (ZAW'(z_addr)),
        .rdata (z_rdata)
    );

    kvz_zone_cmp u_cmp (
        .zone (z_rdata),
        .note (note_reg),
        .vel  (vel_reg),
        .hit  (hit)
    );

    always_comb
    begin
        state_next     = state_reg;
        note_next      = note_reg;
        vel_next       = vel_reg;
        idx_next       = idx_reg;
        nxt_next       = nxt_reg;
        lim_next       = lim_reg;
        res_found_next = res_found_reg;
        res_zone_next  = res_zone_reg;
        out_found_next = out_found_reg;
        out_zone_next  = out_zone_reg;
        out_valid_next = out_valid_reg && !m_tready;
        z_re           = 1'b0;
        z_addr         = nxt_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (s_tuser == ACT_LOOKUP))
                begin
                    note_next = midi_note;
                    vel_next  = note_velocity;
                    if (lk_ok)
                    begin
                        state_next = ST_PRESET;
                    end
                    else
                    begin
                        res_found_next = 1'b0;
                        res_zone_next  = '0;
                        state_next     = ST_DONE;
                    end
                end
            end
            ST_PRESET:
            begin
                z_addr = walk_first;
                if (walk_first < walk_lim)
                begin
                    z_re       = 1'b1;
                    idx_next   = walk_first;
                    nxt_next   = walk_first + 1'b1;
                    lim_next   = walk_lim;
                    state_next = ST_WALK;
                end
                else
                begin
                    res_found_next = 1'b0;
                    res_zone_next  = '0;
                    state_next     = ST_DONE;
                end
            end
            ST_WALK:
            begin
                // z_rdata holds the zone at idx_reg; the next one is fetched meanwhile
                if (hit)
                begin
                    res_found_next = 1'b1;
                    res_zone_next  = idx_reg[ZIDX_W-1:0];
                    state_next     = ST_DONE;
                end
                else if (nxt_reg < lim_reg)
                begin
                    z_re     = 1'b1;
                    idx_next = nxt_reg;
                    nxt_next = nxt_reg + 1'b1;
                end
                else
                begin
                    res_found_next = 1'b0;
                    res_zone_next  = '0;
                    state_next     = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = res_found_reg;
                    out_zone_next  = res_zone_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            note_reg      <= '0;
            vel_reg       <= '0;
            idx_reg       <= '0;
            nxt_reg       <= '0;
            lim_reg       <= '0;
            res_found_reg <= 1'b0;
            res_zone_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_found_reg <= 1'b0;
            out_zone_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            note_reg      <= note_next;
            vel_reg       <= vel_next;
            idx_reg       <= idx_next;
            nxt_reg       <= nxt_next;
            lim_reg       <= lim_next;
            res_found_reg <= res_found_next;
            res_zone_reg  <= res_zone_next;
            out_valid_reg <= out_valid_next;
            out_found_reg <= out_found_next;
            out_zone_reg  <= out_zone_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = M_DATA_W'(out_zone_reg);

`ifndef ASSERT_OFF
    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (idx_reg < lim_reg))
        else $error("zone walk index past its limit");

    a_walk_fresh_data: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> $past(z_re))
        else $error("zone compared without a read the cycle before");

    a_not_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tuser == ACT_LOOKUP) && !loaded_reg) |=>
        ((state_reg == ST_DONE) && !res_found_reg))
        else $error("lookup with tables not loaded did not end at once");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("not found result carries a zone index");
`endif

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for key_velocity_zone_lookup_core, shadows both tables
// and the three registers, predicts every lookup and checks each result item in order
// depends on kvz_pkg and the core rtl

module tb
    import kvz_pkg::*;
();

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 24;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 85;
    localparam int MAX_SETS       = 8;

    // s_tdata layout, lowest field last
    typedef struct packed {
        logic [6:0]         fill;
        logic [NOTE_W-1:0]  note_velocity;
        logic [NOTE_W-1:0]  midi_note;
        logic [NOTE_W-1:0]  vel_high;
        logic [NOTE_W-1:0]  vel_low;
        logic [NOTE_W-1:0]  key_high;
        logic [NOTE_W-1:0]  key_low;
        logic [COUNT_W-1:0] zone_count;
        logic [ZIDX_W-1:0]  first_zone;
        logic [ZIDX_W-1:0]  zone_index;
        logic [PIDX_W-1:0]  preset_index;
    } request_t;

    typedef struct {
        bit                found;
        logic [ZIDX_W-1:0] zone;
    } zone_match_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [ACT_W-1:0]    s_tuser;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;
    logic                cfg_we;
    logic [CFG_AW-1:0]   cfg_addr;
    logic [CFG_DW-1:0]   cfg_wdata;

    // shadow of the block's tables and registers
    preset_entry_t preset_shadow [DEF_PRESETS];
    zone_entry_t   zone_shadow [DEF_ZONES];
    bit            preset_written [DEF_PRESETS];
    bit            zone_written [DEF_ZONES];
    bit                 loaded_reg;
    bit [PIDX_W-1:0]    presets_reg;
    bit [COUNT_W-1:0]   zones_reg;

    zone_match_t expected_matches [$];
    int          mismatch_count;
    bit          tx_steady;
    bit          rx_steady;
    int          rx_hold;
    int          idle_cycles;

    key_velocity_zone_lookup_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // first matching zone of a preset; unsafe flags a never-written preset or a walk over never-written zones
    function automatic void zone_walk(input logic [PIDX_W-1:0] pidx,
                                      input logic [NOTE_W-1:0] note,
                                      input logic [NOTE_W-1:0] vel,
                                      output zone_match_t res, output bit unsafe);
        int          npres;
        int          nzones;
        int          idx;
        int          stop;
        zone_entry_t z;
        res.found = 1'b0;
        res.zone  = '0;
        unsafe    = 1'b0;
        if (!loaded_reg)
            return;
        npres = (presets_reg > DEF_PRESETS) ? DEF_PRESETS : int'(presets_reg);
        if (pidx >= npres)
            return;
        if (!preset_written[pidx])
        begin
            unsafe = 1'b1;
            return;
        end
        nzones = (zones_reg > DEF_ZONES) ? DEF_ZONES : int'(zones_reg);
        idx    = int'(preset_shadow[pidx].first_zone);
        stop   = idx + int'(preset_shadow[pidx].zone_count);
        while (idx < stop && idx < nzones)
        begin
            if (!zone_written[idx])
            begin
                unsafe = 1'b1;
                return;
            end
            z = zone_shadow[idx];
            if (note >= z.key_low && note <= z.key_high &&
                vel >= z.vel_low && vel <= z.vel_high)
            begin
                res.found = 1'b1;
                res.zone  = ZIDX_W'(idx);
                return;
            end
            idx++;
        end
    endfunction

    function automatic request_t random_request();
        request_t req;
        req.fill          = '0;
        req.preset_index  = PIDX_W'($urandom_range(0, 255));
        req.zone_index    = ZIDX_W'($urandom_range(0, 1023));
        req.first_zone    = ZIDX_W'($urandom_range(0, 1023));
        req.zone_count    = COUNT_W'($urandom_range(0, 2047));
        req.key_low       = NOTE_W'($urandom_range(0, 127));
        req.key_high      = NOTE_W'($urandom_range(0, 127));
        req.vel_low       = NOTE_W'($urandom_range(0, 127));
        req.vel_high      = NOTE_W'($urandom_range(0, 127));
        req.midi_note     = NOTE_W'($urandom_range(0, 127));
        req.note_velocity = NOTE_W'($urandom_range(0, 127));
        return req;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        mismatch_count++;
    endtask

    task automatic send_item(input logic [ACT_W-1:0] action, input request_t req);
        zone_match_t res;
        bit          unsafe;
        int          gap;
        if (action == ACT_LOOKUP)
        begin
            zone_walk(req.preset_index, req.midi_note, req.note_velocity, res, unsafe);
            // walking unwritten entries is not allowed: aim the lookup past the presets
            if (unsafe)
            begin
                req.preset_index = '1;
                zone_walk(req.preset_index, req.midi_note, req.note_velocity, res, unsafe);
            end
        end
        req.fill = '0;
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        s_tuser  <= action;
        do
            @(posedge clk);
        while (!s_tready);
        case (action)
            ACT_WR_PRESET:
            begin
                if (req.preset_index < DEF_PRESETS)
                begin
                    preset_shadow[req.preset_index]  = {req.zone_count, req.first_zone};
                    preset_written[req.preset_index] = 1'b1;
                end
            end
            ACT_WR_ZONE:
            begin
                zone_shadow[req.zone_index]  = {req.vel_high, req.vel_low,
                                                req.key_high, req.key_low};
                zone_written[req.zone_index] = 1'b1;
            end
            ACT_LOOKUP:
                expected_matches.push_back(res);
            default:
                ;
        endcase
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_preset(input logic [PIDX_W-1:0] pidx, input int first,
                                input int count);
        request_t req;
        req              = random_request();
        req.preset_index = pidx;
        req.first_zone   = ZIDX_W'(first);
        req.zone_count   = COUNT_W'(count);
        send_item(ACT_WR_PRESET, req);
    endtask

    task automatic write_zone(input int zidx, input int klo, input int khi,
                              input int vlo, input int vhi);
        request_t req;
        req            = random_request();
        req.zone_index = ZIDX_W'(zidx);
        req.key_low    = NOTE_W'(klo);
        req.key_high   = NOTE_W'(khi);
        req.vel_low    = NOTE_W'(vlo);
        req.vel_high   = NOTE_W'(vhi);
        send_item(ACT_WR_ZONE, req);
    endtask

    task automatic lookup_note(input logic [PIDX_W-1:0] pidx, input int note, input int vel);
        request_t req;
        req               = random_request();
        req.preset_index  = pidx;
        req.midi_note     = NOTE_W'(note);
        req.note_velocity = NOTE_W'(vel);
        send_item(ACT_LOOKUP, req);
    endtask

    // mostly sane ranges, some catch-all, some inverted
    task automatic write_random_zone(input int zidx);
        int roll;
        int klo;
        int vlo;
        roll = $urandom_range(0, 9);
        klo  = $urandom_range(0, 127);
        vlo  = $urandom_range(0, 127);
        if (roll == 0)
            write_zone(zidx, 0, 127, 0, 127);
        else if (roll == 1 && klo > 0)
            write_zone(zidx, klo, $urandom_range(0, klo - 1), vlo, 127);
        else if (roll == 2 && vlo > 0)
            write_zone(zidx, 0, 127, vlo, $urandom_range(0, vlo - 1));
        else
            write_zone(zidx, klo, $urandom_range(klo, 127), vlo, $urandom_range(vlo, 127));
    endtask

    task automatic write_random_preset(input logic [PIDX_W-1:0] pidx, input int base,
                                       input int span);
        int roll;
        int offset;
        roll   = $urandom_range(0, 9);
        offset = $urandom_range(0, span - 1);
        if (roll == 0)
            write_preset(pidx, base + offset, 0);
        else if (roll == 1)
            write_preset(pidx, base + offset, $urandom_range(0, 2047));
        else
            write_preset(pidx, base + offset, $urandom_range(1, span - offset));
    endtask

    task automatic wait_for_idle();
        s_tvalid <= 1'b0;
        while (expected_matches.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input bit loaded, input logic [PIDX_W-1:0] presets,
                              input logic [COUNT_W-1:0] zones);
        wait_for_idle();
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_TABLE_LOADED;
        cfg_wdata <= CFG_DW'(loaded);
        @(posedge clk);
        cfg_addr  <= CFG_PRESETS_IN_USE;
        cfg_wdata <= CFG_DW'(presets);
        @(posedge clk);
        cfg_addr  <= CFG_ZONES_IN_USE;
        cfg_wdata <= CFG_DW'(zones);
        @(posedge clk);
        cfg_we      <= 1'b0;
        loaded_reg  = loaded;
        presets_reg = presets;
        zones_reg   = zones;
    endtask

    // registers at reset, then tables not loaded, plus the unused action
    task automatic test_not_loaded();
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        lookup_note(0, 0, 0);
        lookup_note(127, 127, 127);
        lookup_note(255, 64, 1);
        send_item(ACT_UNUSED, random_request());
        send_item(ACT_UNUSED, random_request());
        write_preset(200, 1023, 2047);
        set_config(1'b0, 128, 1024);
        lookup_note(0, 60, 100);
        lookup_note(64, 0, 127);
    endtask

    task automatic test_directed_walk();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        write_zone(0, 0, 127, 0, 127);
        write_zone(1, 60, 60, 100, 100);
        write_zone(2, 70, 50, 0, 127);
        write_zone(3, 0, 127, 127, 127);
        write_zone(4, 127, 127, 0, 0);
        write_zone(5, 40, 80, 0, 63);
        write_zone(6, 40, 80, 64, 127);
        write_preset(0, 1, 6);
        write_preset(1, 2, 1);
        write_preset(2, 0, 0);
        write_preset(3, 5, 2047);
        set_config(1'b1, 4, 7);
        lookup_note(0, 60, 100);
        lookup_note(0, 60, 99);
        lookup_note(0, 127, 0);
        lookup_note(0, 0, 127);
        lookup_note(0, 0, 0);
        lookup_note(1, 60, 10);
        lookup_note(2, 60, 100);
        // walk cut short by zones_in_use
        lookup_note(3, 90, 90);
        lookup_note(4, 60, 100);
        // counts above the table sizes
        set_config(1'b1, 255, 2047);
        write_zone(1023, 0, 127, 0, 127);
        write_preset(127, 1023, 2047);
        write_preset(128, 0, 1);
        lookup_note(3, 60, 100);
        lookup_note(127, 127, 127);
        lookup_note(128, 0, 0);
        set_config(1'b1, 128, 1023);
        lookup_note(127, 5, 5);
        set_config(1'b1, 0, 1024);
        lookup_note(0, 60, 100);
    endtask

    // per phase: new settings, a zone window with presets over it, then mixed traffic
    task automatic test_random_phases();
        int                phase;
        int                base;
        int                span;
        int                nsets;
        int                roll;
        int                i;
        int                npres;
        logic [PIDX_W-1:0] sets [MAX_SETS];
        logic [PIDX_W-1:0] presets;
        logic [COUNT_W-1:0] zones;
        zone_entry_t       z;
        for (phase = 0; phase < PHASES; phase++)
        begin
            roll = $urandom_range(0, 9);
            presets = PIDX_W'((roll < 6) ? 128 : (roll == 6) ? 255 : (roll == 7) ? 0 :
                              $urandom_range(1, 255));
            roll = $urandom_range(0, 9);
            zones = COUNT_W'((roll < 5) ? 1024 : (roll == 5) ? 2047 : (roll == 6) ? 0 :
                             $urandom_range(1, 2047));
            set_config($urandom_range(0, 9) != 0, presets, zones);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);

            base = $urandom_range(0, DEF_ZONES - 1);
            span = $urandom_range(4, 48);
            if (base + span > DEF_ZONES)
                span = DEF_ZONES - base;
            for (i = 0; i < span; i++)
                write_random_zone(base + i);

            npres = (presets_reg > DEF_PRESETS) ? DEF_PRESETS : int'(presets_reg);
            nsets = $urandom_range(2, MAX_SETS);
            for (i = 0; i < nsets; i++)
            begin
                sets[i] = PIDX_W'((npres == 0) ? $urandom_range(0, DEF_PRESETS - 1) :
                                  $urandom_range(0, npres - 1));
                write_random_preset(sets[i], base, span);
            end

            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 47)
                begin
                    // note and velocity taken between the bounds of some zone of the window
                    z = zone_shadow[base + $urandom_range(0, span - 1)];
                    lookup_note(sets[$urandom_range(0, nsets - 1)],
                                $urandom_range(z.key_low, z.key_high),
                                $urandom_range(z.vel_low, z.vel_high));
                end
                else if (roll < 70)
                    lookup_note(sets[$urandom_range(0, nsets - 1)],
                                $urandom_range(0, 127), $urandom_range(0, 127));
                else if (roll < 78)
                    write_random_zone(base + $urandom_range(0, span - 1));
                else if (roll < 83)
                    write_random_preset(sets[$urandom_range(0, nsets - 1)], base, span);
                else if (roll < 90)
                    lookup_note(PIDX_W'($urandom_range(0, 255)), $urandom_range(0, 127),
                                $urandom_range(0, 127));
                else if (roll < 97)
                    send_item(ACT_W'($urandom_range(0, 3)), random_request());
                else
                    wait_for_idle();
            end
        end
    endtask

    task automatic check_result();
        zone_match_t want;
        if (expected_matches.size() == 0)
        begin
            report_mismatch("unexpected result item", '0, 32'({m_tuser, m_tdata}));
            return;
        end
        want = expected_matches.pop_front();
        if (m_tuser !== want.found)
            report_mismatch("found", 32'(want.found), 32'(m_tuser));
        if (m_tdata[ZIDX_W-1:0] !== want.zone)
            report_mismatch("zone_result", 32'(want.zone), 32'(m_tdata[ZIDX_W-1:0]));
    endtask

    // result side: check each accepted item, then decide the next ready
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_result();
        if (rx_steady)
            m_tready <= 1'b1;
        else if (rx_hold > 0)
        begin
            rx_hold  = rx_hold - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            rx_hold = pick_gap();
            if (rx_hold == 0)
                m_tready <= 1'b1;
            else
            begin
                rx_hold  = rx_hold - 1;
                m_tready <= 1'b0;
            end
        end
    end

    // cycles without any item moving on either side
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("key_velocity_zone_lookup_core test failed");
        $finish;
    end

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= ACT_UNUSED;
        cfg_we    <= 1'b0;
        cfg_addr  <= CFG_TABLE_LOADED;
        cfg_wdata <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_not_loaded();
        test_directed_walk();
        test_random_phases();

        wait_for_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("key_velocity_zone_lookup_core test passed");
        else
            $display("key_velocity_zone_lookup_core test failed");
        $finish;
    end

endmodule
